[rtl/core/lsb_first_bit_stream_packer_defines.svh]
// ---------------------------------------------------------------------------
// lsb_first_bit_stream_packer_defines.svh
// Assertion macros for the bit stream packer. Each macro uses the clock and
// reset of the module that expands it.
// ---------------------------------------------------------------------------
`ifndef LSB_FIRST_BIT_STREAM_PACKER_DEFINES_SVH
`define LSB_FIRST_BIT_STREAM_PACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBSP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LBSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/lbsp_pkg.sv]
// ---------------------------------------------------------------------------
// lbsp_pkg
// Shared types and constants of the LSB-first bit stream packer.
// ---------------------------------------------------------------------------
package lbsp_pkg;

   // Field widths
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 6;
   localparam int LIMIT_W  = 13;
   localparam int OFFSET_W = 12;
   localparam int BYTE_W   = 8;
   localparam int BITPOS_W = 3;
   localparam int IDX_W    = 3;
   localparam int ACC_W    = VALUE_W + BYTE_W;
   localparam int MAX_FULL = 4;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   localparam int DEFAULT_BUFFER_BYTES = 4096;
   localparam logic [LIMIT_W-1:0] MAX_BYTES_RESET = 13'd4096;
   localparam logic [COUNT_W-1:0] COUNT_SAT = 6'd32;

   // Item kind carried on the request tuser
   typedef enum logic {
      MODE_APPEND = 1'b0,
      MODE_RESET  = 1'b1
   } mode_type;

   // Fill position and sticky flag
   typedef struct packed {
      logic [BYTE_W-1:0]   partial;
      logic [BITPOS_W-1:0] bit_pos;
      logic [LIMIT_W-1:0]  byte_pos;
      logic                ovf;
   } state_type;

   // Everything the output side needs to play back one item's results
   typedef struct packed {
      logic [MAX_FULL-1:0][BYTE_W-1:0] bytes;
      logic [OFFSET_W-1:0]             base_off;
      logic [IDX_W-1:0]                n_full;
      logic                            old_ovf;
      logic [BYTE_W-1:0]               snap_byte;
      logic [BITPOS_W-1:0]             snap_held;
      logic                            snap_ovf;
   } job_type;

endpackage

[rtl/core/lbsp_merge.sv]
// ---------------------------------------------------------------------------
// lbsp_merge
// Merges one item into the fill state: shifts the new bits above the held
// bits, splits off full bytes within the limit, and forms the next state.
// ---------------------------------------------------------------------------
module lbsp_merge (
   input  lbsp_pkg::mode_type                  mode,
   input  logic [lbsp_pkg::VALUE_W-1:0]        value,
   input  logic [lbsp_pkg::COUNT_W-1:0]        bit_count,
   input  lbsp_pkg::state_type                 cur,
   input  logic [lbsp_pkg::LIMIT_W-1:0]        limit,
   output lbsp_pkg::state_type                 nxt,
   output lbsp_pkg::job_type                   job
);
   import lbsp_pkg::*;

   logic [COUNT_W-1:0]  count_sat;
   logic [VALUE_W-1:0]  val_mask;
   logic [ACC_W-1:0]    acc;
   logic [COUNT_W-1:0]  total;
   logic [IDX_W-1:0]    full;
   logic [LIMIT_W-1:0]  room;
   logic [IDX_W-1:0]    emit_n;
   logic [BYTE_W-1:0]   rem_byte;
   logic [BYTE_W-1:0]   rem_mask;

   // Saturate count and mask off unused value bits
   assign count_sat = (bit_count > COUNT_SAT) ? COUNT_SAT : bit_count;
   assign val_mask  = (count_sat == COUNT_SAT) ? '1 : ~('1 << count_sat[4:0]);

   // Held bits stay below, new bits go on top
   assign acc   = ({{BYTE_W{1'b0}}, value & val_mask} << cur.bit_pos)
                | {{VALUE_W{1'b0}}, cur.partial};
   assign total = {{(COUNT_W-BITPOS_W){1'b0}}, cur.bit_pos} + count_sat;
   assign full  = total[COUNT_W-1:BITPOS_W];

   // Bytes that still fit below the limit
   assign room   = (cur.byte_pos < limit) ? (limit - cur.byte_pos) : '0;
   assign emit_n = (room < {{(LIMIT_W-IDX_W){1'b0}}, full}) ? room[IDX_W-1:0] : full;

   // Leftover bits after the full bytes
   always_comb begin
      case (full)
         3'd0:    rem_byte = acc[7:0];
         3'd1:    rem_byte = acc[15:8];
         3'd2:    rem_byte = acc[23:16];
         3'd3:    rem_byte = acc[31:24];
         3'd4:    rem_byte = acc[39:32];
         default: rem_byte = '0;
      endcase
   end
   assign rem_mask = ~(8'hFF << total[BITPOS_W-1:0]);

   // Next state and playback description
   always_comb begin
      for (int k = 0; k < MAX_FULL; k++) begin
         job.bytes[k] = acc[k*BYTE_W +: BYTE_W];
      end
      job.old_ovf  = cur.ovf;
      if (mode == MODE_RESET) begin
         nxt           = '0;
         job.base_off  = '0;
         job.n_full    = '0;
         job.snap_byte = '0;
         job.snap_held = '0;
         job.snap_ovf  = 1'b0;
      end else begin
         nxt.partial   = rem_byte & rem_mask;
         nxt.bit_pos   = total[BITPOS_W-1:0];
         nxt.byte_pos  = cur.byte_pos + {{(LIMIT_W-IDX_W){1'b0}}, emit_n};
         nxt.ovf       = cur.ovf | (emit_n != full);
         job.base_off  = cur.byte_pos[OFFSET_W-1:0];
         job.n_full    = emit_n;
         job.snap_byte = rem_byte & rem_mask;
         job.snap_held = total[BITPOS_W-1:0];
         job.snap_ovf  = cur.ovf | (emit_n != full);
      end
   end

endmodule

[rtl/core/lbsp_drain.sv]
// ---------------------------------------------------------------------------
// lbsp_drain
// Result buffer: holds one item's results and hands them out one word per
// cycle while rsp_tready is high, full bytes first, then the partial byte snapshot.
// ---------------------------------------------------------------------------
module lbsp_drain (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  lbsp_pkg::job_type                    job_in,
   output logic                                 free,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lbsp_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // byte_value, byte_offset,
                                                            // bits_held, overflow
   output logic                                 rsp_tuser,  // complete
   output logic                                 rsp_tlast   // last
);
   import lbsp_pkg::*;

   job_type            job_ff;
   logic               busy_ff, busy_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               is_snap;
   logic               take;
   logic [BYTE_W-1:0]  out_byte;
   logic [OFFSET_W-1:0] out_off;

   assign is_snap = (idx_ff == job_ff.n_full);
   assign take    = busy_ff && rsp_tready;
   assign free    = !busy_ff || (take && is_snap);

   // Control next values
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (take) begin
         if (is_snap) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job_in;
      end
   end

   // Current word; offset of word k is base plus k
   assign out_byte = is_snap ? job_ff.snap_byte : job_ff.bytes[idx_ff[1:0]];
   assign out_off  = job_ff.base_off + {{(OFFSET_W-IDX_W){1'b0}}, idx_ff};

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {is_snap ? job_ff.snap_ovf : job_ff.old_ovf,
                        is_snap ? job_ff.snap_held : 3'd0,
                        out_off, out_byte};
   assign rsp_tuser  = !is_snap;
   assign rsp_tlast  = is_snap;

endmodule

[rtl/core/lsb_first_bit_stream_packer.sv]
// ---------------------------------------------------------------------------
// lsb_first_bit_stream_packer
// Packs 0 to 32 bit values LSB first into a byte stream with a byte limit
// and a sticky overflow flag.
//
//   Channel  Dir  Moves
//   req_*    in   one item: mode on tuser, value and bit_count on tdata
//   rsp_*    out  one byte result; complete on tuser, tlast on final word
//   csr_*    in   max_bytes write, no read-back
//
// An item gives 1 plus the full bytes it emits as results, so 1 to 5; the
// result port hands them out one word per cycle while rsp_tready is high.
// Results start the cycle after the item leaves the input register.
// The input register takes a new item while results are still draining.
// Synchronous active-high reset clears all control state and sets the
// limit back to 4096.
// ---------------------------------------------------------------------------
module lsb_first_bit_stream_packer #(
   parameter int BUFFER_BYTES = lbsp_pkg::DEFAULT_BUFFER_BYTES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lbsp_pkg::REQ_DATA_W-1:0]      req_tdata,  // value, bit_count
   input  logic                                 req_tuser,  // mode
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lbsp_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // byte_value, byte_offset,
                                                            // bits_held, overflow
   output logic                                 rsp_tuser,  // complete
   output logic                                 rsp_tlast,  // last
   input  logic                                 csr_wr_en,
   input  logic [lbsp_pkg::LIMIT_W-1:0]         csr_wr_data // max_bytes
);
   import lbsp_pkg::*;

`include "lsb_first_bit_stream_packer_defines.svh"

   // Buffer size clipped to what the limit register can express
   localparam int MaxLimit = (1 << LIMIT_W) - 1;
   localparam int BufCap   = (BUFFER_BYTES > MaxLimit) ? MaxLimit : BUFFER_BYTES;
   localparam logic [LIMIT_W-1:0] BufCapW = LIMIT_W'(BufCap);

   logic [LIMIT_W-1:0]  max_bytes_ff;
   logic [LIMIT_W-1:0]  limit;
   logic                in_valid_ff, in_valid_in;
   mode_type            in_mode_ff;
   logic [VALUE_W-1:0]  in_value_ff;
   logic [COUNT_W-1:0]  in_count_ff;
   state_type           state_ff, state_in;
   job_type             job;
   logic                free;
   logic                load;
   logic                req_take;

   // Limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_BYTES_RESET;
      end else if (csr_wr_en) begin
         max_bytes_ff <= csr_wr_data;
      end
   end
   assign limit = (max_bytes_ff > BufCapW) ? BufCapW : max_bytes_ff;

   // Input register
   assign load        = in_valid_ff && free;
   assign req_tready  = !in_valid_ff || free;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !load);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff  <= mode_type'(req_tuser);
         in_value_ff <= req_tdata[VALUE_W-1:0];
         in_count_ff <= req_tdata[VALUE_W +: COUNT_W];
      end
   end

   // Merge logic
   lbsp_merge u_merge (
      .mode      (in_mode_ff),
      .value     (in_value_ff),
      .bit_count (in_count_ff),
      .cur       (state_ff),
      .limit     (limit),
      .nxt       (state_in),
      .job       (job)
   );

   // Fill state, updated as an item moves into the result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (load) begin
         state_ff <= state_in;
      end
   end

   // Result buffer
   lbsp_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .job_in     (job),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Checks
   `LBSP_ASSERT_SAME(a_last_is_snapshot, rsp_tvalid, rsp_tlast == !rsp_tuser,
                     "last must mark the snapshot only")
   `LBSP_ASSERT_SAME(a_snapshot_matches_state, rsp_tvalid && rsp_tlast,
                     (rsp_tdata[22:20] == state_ff.bit_pos) &&
                     (rsp_tdata[7:0] == state_ff.partial) &&
                     (rsp_tdata[23] == state_ff.ovf),
                     "snapshot differs from fill state")
   `LBSP_ASSERT_NEXT(a_overflow_sticky,
                     state_ff.ovf && !(load && (in_mode_ff == MODE_RESET)), state_ff.ovf,
                     "overflow cleared without reset item")
   `LBSP_ASSERT_SAME(a_no_overwrite, req_take && in_valid_ff, load,
                     "input register overwritten while full")

endmodule

[sim/lsb_first_bit_stream_packer_test.sv]
// ---------------------------------------------------------------------------
// lsb_first_bit_stream_packer_test
// Self-checking bench for the LSB-first bit stream packer. A short table of
// directed words comes first, then random append and restart words under
// several byte limits.
// Every result word is checked field by field against a known table row or
// an in-bench packing model. Both sides of the stream idle and stall at random.
// ---------------------------------------------------------------------------
module lsb_first_bit_stream_packer_test;
   import lbsp_pkg::*;

   localparam int SETTLE_CYCLES = 8;      // quiet time after the last result
   localparam int QUIET_LIMIT   = 2000;   // cycles with no handshake at all

   // One result word as the packer reports it
   typedef struct packed {
      logic [BYTE_W-1:0]   byte_value;
      logic [OFFSET_W-1:0] byte_offset;
      logic                complete;
      logic [BITPOS_W-1:0] bits_held;
      logic                overflow;
      logic                last;
   } byte_result_type;

   // One directed word; want is used only where known is set
   typedef struct packed {
      mode_type           mode;
      logic [31:0]        value;
      logic [COUNT_W-1:0] count;
      logic               known;
      byte_result_type    want;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;

   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // value, bit_count
   logic                  req_tuser   = 1'b0; // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // byte_value, byte_offset,
                                              // bits_held, overflow
   logic                  rsp_tuser;          // complete
   logic                  rsp_tlast;          // last
   logic                  csr_wr_en   = 1'b0;
   logic [LIMIT_W-1:0]    csr_wr_data = '0;   // max_bytes

   // Packing model state
   logic [BYTE_W-1:0]   fill_byte = '0;
   logic [BITPOS_W-1:0] fill_bits = '0;
   logic [LIMIT_W-1:0]  fill_pos  = '0;
   logic                fill_ovf  = 1'b0;
   logic [LIMIT_W-1:0]  limit_reg = MAX_BYTES_RESET;

   byte_result_type packed_out [0:MAX_FULL];
   byte_result_type pending_bytes [$];

   int  errors = 0;
   int  quiet  = 0;
   int  sink_wait = 0;
   bit  idle_on = 1'b1;

   localparam stim_row_type DIRECTED_ROWS [0:19] = '{
      // restart right after reset: cleared snapshot
      '{MODE_RESET,  32'hFFFF_FFFF, 6'd63, 1'b1, '{8'h00, 12'd0, 1'b0, 3'd0, 1'b0, 1'b1}},
      // zero bits: snapshot of an empty byte
      '{MODE_APPEND, 32'hFFFF_FFFF, 6'd0,  1'b1, '{8'h00, 12'd0, 1'b0, 3'd0, 1'b0, 1'b1}},
      // seven ones: partial byte only
      '{MODE_APPEND, 32'hFFFF_FFFF, 6'd7,  1'b1, '{8'h7F, 12'd0, 1'b0, 3'd7, 1'b0, 1'b1}},
      '{MODE_APPEND, 32'h0000_0000, 6'd1,  1'b0, '0},
      '{MODE_APPEND, 32'hFFFF_FFFF, 6'd32, 1'b0, '0},
      '{MODE_APPEND, 32'h0000_0005, 6'd3,  1'b0, '0},
      '{MODE_APPEND, 32'h0000_0000, 6'd32, 1'b0, '0},
      // counts above 32 saturate
      '{MODE_APPEND, 32'hDEAD_BEEF, 6'd63, 1'b0, '0},
      '{MODE_APPEND, 32'h1234_5678, 6'd33, 1'b0, '0},
      '{MODE_APPEND, 32'h0000_001F, 6'd5,  1'b0, '0},
      '{MODE_APPEND, 32'h0000_0003, 6'd2,  1'b0, '0},
      // two bits held plus 32 gives four full bytes
      '{MODE_APPEND, 32'hA5A5_A5A5, 6'd32, 1'b0, '0},
      '{MODE_APPEND, 32'h8000_0000, 6'd32, 1'b0, '0},
      // restart mid-stream
      '{MODE_RESET,  32'h5A5A_5A5A, 6'd17, 1'b1, '{8'h00, 12'd0, 1'b0, 3'd0, 1'b0, 1'b1}},
      '{MODE_APPEND, 32'h0000_0001, 6'd1,  1'b0, '0},
      '{MODE_APPEND, 32'h7FFF_FFFF, 6'd31, 1'b0, '0},
      '{MODE_APPEND, 32'hFFFF_FFFF, 6'd16, 1'b0, '0},
      // upper value bits beyond the count are masked off
      '{MODE_APPEND, 32'hFF00_FFFF, 6'd24, 1'b0, '0},
      '{MODE_APPEND, 32'hFFFF_FF55, 6'd8,  1'b0, '0},
      '{MODE_APPEND, 32'hFFFF_FFAA, 6'd6,  1'b0, '0}
   };

   lsb_first_bit_stream_packer uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Packing model: fills packed_out, returns the number of results
   function automatic int pack_bits(input mode_type mode, input logic [31:0] value,
                                    input logic [COUNT_W-1:0] count);
      logic [ACC_W-1:0]   acc;
      logic [COUNT_W-1:0] n_bits;
      logic [COUNT_W-1:0] total;
      int                 limit;
      int                 n;
      n = 0;
      limit = (limit_reg > DEFAULT_BUFFER_BYTES) ? DEFAULT_BUFFER_BYTES : int'(limit_reg);
      if (mode == MODE_RESET) begin
         fill_byte = '0;
         fill_bits = '0;
         fill_pos  = '0;
         fill_ovf  = 1'b0;
         packed_out[0] = '{8'h00, 12'd0, 1'b0, 3'd0, 1'b0, 1'b1};
         return 1;
      end
      n_bits = (count > COUNT_SAT) ? COUNT_SAT : count;
      acc = ACC_W'(value) & ((ACC_W'(1) << n_bits) - ACC_W'(1));
      acc = (acc << fill_bits) | ACC_W'(fill_byte & ((8'd1 << fill_bits) - 8'd1));
      total = COUNT_W'(fill_bits) + n_bits;
      for (int i = 0; i < int'(total) / 8; i++) begin
         // a byte past the limit is dropped and marks overflow
         if (int'(fill_pos) < limit) begin
            packed_out[n] = '{acc[7:0], fill_pos[OFFSET_W-1:0], 1'b1, 3'd0, fill_ovf, 1'b0};
            n++;
            fill_pos = fill_pos + LIMIT_W'(1);
         end else begin
            fill_ovf = 1'b1;
         end
         acc = acc >> 8;
      end
      fill_bits = total[BITPOS_W-1:0];
      fill_byte = acc[7:0] & ((8'd1 << fill_bits) - 8'd1);
      packed_out[n] = '{fill_byte, fill_pos[OFFSET_W-1:0], 1'b0, fill_bits, fill_ovf, 1'b1};
      return n + 1;
   endfunction

   // Present one word, wait for the handshake, queue what it must produce
   task automatic send_word(input mode_type mode, input logic [31:0] value,
                            input logic [COUNT_W-1:0] count, input logic known,
                            input byte_result_type want);
      int gap;
      int n;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, count, value};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      n = pack_bits(mode, value, count);
      if (known) begin
         pending_bytes.push_back(want);
      end else begin
         for (int i = 0; i < n; i++) pending_bytes.push_back(packed_out[i]);
      end
   endtask

   // Hold off the sender until every result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Limit writes happen only with the block idle
   task automatic write_max_bytes(input logic [LIMIT_W-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      limit_reg = value;
      csr_wr_en <= 1'b0;
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                  $time, name, want, want, got, got);
      end
   endfunction

   // Result sink: random stall per word
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sink_wait = idle_on ? $urandom_range(0, 7) : 0;
      if (sink_wait > 0) begin
         rsp_tready <= 1'b0;
         sink_wait--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker
   always @(posedge clock) begin
      byte_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, data 0x%0h complete %0b last %0b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = pending_bytes.pop_front();
            check_field("byte_value",  want.byte_value,  rsp_tdata[7:0]);
            check_field("byte_offset", want.byte_offset, rsp_tdata[19:8]);
            check_field("bits_held",   want.bits_held,   rsp_tdata[22:20]);
            check_field("overflow",    want.overflow,    rsp_tdata[23]);
            check_field("complete",    want.complete,    rsp_tuser);
            check_field("last",        want.last,        rsp_tlast);
         end
      end
   end

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      int                 phase_limits [6];
      int                 roll;
      mode_type           mode;
      logic [31:0]        value;
      logic [COUNT_W-1:0] count;

      phase_limits = '{0, 1, $urandom_range(2, 24), $urandom_range(2, 24), 4096, 8191};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table under the reset limit
      foreach (DIRECTED_ROWS[i])
         send_word(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].count,
                   DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);

      // random words under several limits; phase 3 runs without idling
      for (int ph = 0; ph < 6; ph++) begin
         write_max_bytes(LIMIT_W'(phase_limits[ph]));
         idle_on = (ph != 3);
         send_word(MODE_RESET, $urandom, COUNT_W'($urandom), 1'b0, '0);
         for (int k = 0; k < 17; k++) begin
            roll  = $urandom_range(0, 99);
            mode  = (roll < 6) ? MODE_RESET : MODE_APPEND;
            count = (roll >= 6 && roll < 14) ? COUNT_W'($urandom_range(33, 63))
                                             : COUNT_W'($urandom_range(0, 32));
            roll  = $urandom_range(0, 99);
            value = (roll < 10) ? 32'hFFFF_FFFF : (roll < 20) ? 32'h0 : 32'($urandom);
            if (ph == 2 && k == 10) drain_results();
            send_word(mode, value, count, 1'b0, '0);
         end
      end
      idle_on = 1'b1;

      drain_results();
      if (errors == 0 && pending_bytes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
